[sv/idba_pkg.sv]
// Shared constants for the integer box-average downscaler.
// Used by the top level, the port checker and the testbench; depends on nothing.
`default_nettype none

package idba_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int DEF_MAX_WIDTH   = 2048;
   localparam int DEF_MAX_SCALE   = 16;
   localparam int DEF_SAMPLE_BITS = 8;

   localparam int CHANNELS       = 3;
   localparam int HEIGHT_BITS    = 16;
   localparam int SCALE_REG_BITS = 5;
   localparam int WIDTH_REG_BITS = 12;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // A scale register of zero acts as this factor.
   localparam int ZERO_SCALE = 2;

   localparam int RST_SCALE  = 2;
   localparam int RST_WIDTH  = 640;
   localparam int RST_HEIGHT = 480;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type REG_SCALE_Y      = 3'd0;
   localparam csr_index_type REG_SCALE_X      = 3'd1;
   localparam csr_index_type REG_SMOOTH_MODE  = 3'd2;
   localparam csr_index_type REG_IMAGE_WIDTH  = 3'd3;
   localparam csr_index_type REG_IMAGE_HEIGHT = 3'd4;

endpackage

`default_nettype wire

[sv/idba_divider.sv]
// Restoring divider, one quotient bit per cycle, for the downscaler's setup pass.
// Stand-alone; takes no package items.
`default_nettype none

module idba_divider #(
   parameter int NW = 16,
   parameter int DW = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start_i,
   input  wire logic [NW-1:0] dividend_i,
   input  wire logic [DW-1:0] divisor_i,
   output logic               busy_o,
   output logic [NW-1:0]      quotient_o,
   output logic [DW-1:0]      remainder_o
);

   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff;
   logic [NW-1:0] quo_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] div_ff;

   logic [DW:0]   shifted;
   logic          fits;
   logic [DW:0]   diff;
   logic [DW-1:0] rem_in;
   logic [NW-1:0] quo_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[NW-1]};
      fits    = shifted >= {1'b0, div_ff};
      diff    = shifted - {1'b0, div_ff};
      // Without a subtraction the shifted remainder is still below the divisor.
      rem_in  = fits ? diff[DW-1:0] : shifted[DW-1:0];
      quo_in  = {quo_ff[NW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start_i) begin
         cnt_ff <= CW'(NW);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start_i) begin
         quo_ff <= dividend_i;
         rem_ff <= '0;
         div_ff <= divisor_i;
      end else if (cnt_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy_o      = cnt_ff != '0;
   assign quotient_o  = quo_ff;
   assign remainder_o = rem_ff;

endmodule

`default_nettype wire

[sv/integer_downscale_box_average.sv]
// Top level of the integer box-average downscaler for RGB raster streams.
// Depends on idba_pkg and idba_divider.
//
// Usage: pixels enter on the req_ channel in raster order, one word per pixel;
// req_frame_start restarts column and row counting at that pixel. Reduced pixels
// leave on the rsp_ channel in raster order with row_last and frame_last marks.
// In pick mode the top-left pixel of each block is sent, in smooth mode the
// truncated mean of the block once its bottom-right pixel arrives.
// Throughput: one pixel per clock while no setup pass runs and the receiver
// takes words. The per-column sums live in a single RAM with a registered
// read; the read-modify-write runs one pixel per clock with forwarding between
// neighbouring pixels of the same block. A result passes the s1, s2, s3 and
// output registers before rsp_valid shows it (RAM read, sum update, reciprocal
// multiply, remainder correction). Reset and every csr_ write start a setup
// pass; req_ready stays low meanwhile while the dividers derive block
// positions, output sizes and the reciprocal of the block area. The user must
// write registers only while the stream is idle; the block does not enforce it.
// When the receiver stalls, the whole pipeline holds and req_ready drops.
`default_nettype none

module integer_downscale_box_average #(
   parameter int MAX_WIDTH   = idba_pkg::DEF_MAX_WIDTH,
   parameter int MAX_SCALE   = idba_pkg::DEF_MAX_SCALE,
   parameter int SAMPLE_BITS = idba_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [SAMPLE_BITS-1:0]             req_red_in,
   input  wire logic [SAMPLE_BITS-1:0]             req_green_in,
   input  wire logic [SAMPLE_BITS-1:0]             req_blue_in,
   input  wire logic                               req_frame_start,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [SAMPLE_BITS-1:0]                  rsp_red_out,
   output logic [SAMPLE_BITS-1:0]                  rsp_green_out,
   output logic [SAMPLE_BITS-1:0]                  rsp_blue_out,
   output logic                                    rsp_row_last,
   output logic                                    rsp_frame_last,
   input  wire logic                               csr_we,
   input  wire idba_pkg::csr_index_type            csr_index,
   input  wire logic [idba_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int SW = $clog2(MAX_SCALE + 1);
   localparam int DB = 2 * SW;
   localparam int K  = SAMPLE_BITS + 2 * $clog2(MAX_SCALE);
   localparam int PW = 2 * K;
   localparam int QW = K + DB;
   localparam int HB = idba_pkg::HEIGHT_BITS;
   localparam int CH = idba_pkg::CHANNELS;
   localparam int RST_W = (idba_pkg::RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : idba_pkg::RST_WIDTH;

   localparam logic [1:0] ST_SETTLE = 2'd0;
   localparam logic [1:0] ST_START  = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_RUN    = 2'd3;

   // ---------------- configuration ----------------
   logic [SW-1:0] sy_ff, sx_ff;
   logic          smooth_ff;
   logic [XW:0]   w_ff;
   logic [HB-1:0] h_ff;
   logic [DB-1:0] d_ff;

   logic [idba_pkg::SCALE_REG_BITS-1:0] scale_raw;
   logic [idba_pkg::WIDTH_REG_BITS-1:0] width_raw;
   logic [HB-1:0]                       height_raw;
   logic [SW-1:0]                       scale_eff;
   logic [XW:0]                         width_eff;
   logic [HB-1:0]                       height_eff;

   always_comb begin
      scale_raw  = csr_wdata[idba_pkg::SCALE_REG_BITS-1:0];
      width_raw  = csr_wdata[idba_pkg::WIDTH_REG_BITS-1:0];
      height_raw = csr_wdata[HB-1:0];
      if (scale_raw == '0) begin
         scale_eff = SW'(idba_pkg::ZERO_SCALE);
      end else if (int'(scale_raw) > MAX_SCALE) begin
         scale_eff = SW'(MAX_SCALE);
      end else begin
         scale_eff = SW'(scale_raw);
      end
      if (width_raw == '0) begin
         width_eff = (XW+1)'(1);
      end else if (int'(width_raw) > MAX_WIDTH) begin
         width_eff = (XW+1)'(MAX_WIDTH);
      end else begin
         width_eff = (XW+1)'(width_raw);
      end
      height_eff = (height_raw == '0) ? HB'(1) : height_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sy_ff     <= SW'(idba_pkg::RST_SCALE);
         sx_ff     <= SW'(idba_pkg::RST_SCALE);
         smooth_ff <= 1'b0;
         w_ff      <= (XW+1)'(RST_W);
         h_ff      <= HB'(idba_pkg::RST_HEIGHT);
      end else if (csr_we) begin
         unique case (csr_index)
            idba_pkg::REG_SCALE_Y:      sy_ff     <= scale_eff;
            idba_pkg::REG_SCALE_X:      sx_ff     <= scale_eff;
            idba_pkg::REG_SMOOTH_MODE:  smooth_ff <= csr_wdata[0];
            idba_pkg::REG_IMAGE_WIDTH:  w_ff      <= width_eff;
            idba_pkg::REG_IMAGE_HEIGHT: h_ff      <= height_eff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= DB'(sx_ff) * DB'(sy_ff);
   end

   // ---------------- setup pass ----------------
   logic [1:0] state_ff, state_in;
   logic       div_start;
   logic       div_busy;
   logic       load;

   logic [4:0]    busy_v;
   logic [XW-1:0] quo_x;
   logic [SW-1:0] rem_x;
   logic [HB-1:0] quo_y;
   logic [SW-1:0] rem_y;
   logic [XW:0]   quo_w;
   logic [HB-1:0] quo_h;
   logic [K:0]    quo_r;

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_SETTLE: state_in = ST_START;
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy) state_in = ST_RUN;
         end
         ST_RUN: state_in = ST_RUN;
         default: state_in = ST_SETTLE;
      endcase
      if (csr_we) state_in = ST_SETTLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SETTLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign div_busy = |busy_v;
   assign load     = (state_ff == ST_DIV) && !div_busy;

   idba_divider #(.NW(XW), .DW(SW)) u_div_x (
      .clock(clock), .reset(reset), .start_i(div_start),
      .dividend_i(x_ff), .divisor_i(sx_ff),
      .busy_o(busy_v[0]), .quotient_o(quo_x), .remainder_o(rem_x)
   );

   idba_divider #(.NW(HB), .DW(SW)) u_div_y (
      .clock(clock), .reset(reset), .start_i(div_start),
      .dividend_i(y_ff), .divisor_i(sy_ff),
      .busy_o(busy_v[1]), .quotient_o(quo_y), .remainder_o(rem_y)
   );

   idba_divider #(.NW(XW+1), .DW(SW)) u_div_w (
      .clock(clock), .reset(reset), .start_i(div_start),
      .dividend_i(w_ff), .divisor_i(sx_ff),
      .busy_o(busy_v[2]), .quotient_o(quo_w), .remainder_o()
   );

   idba_divider #(.NW(HB), .DW(SW)) u_div_h (
      .clock(clock), .reset(reset), .start_i(div_start),
      .dividend_i(h_ff), .divisor_i(sy_ff),
      .busy_o(busy_v[3]), .quotient_o(quo_h), .remainder_o()
   );

   // Reciprocal of the block area, scaled by two to the sum width.
   idba_divider #(.NW(K+1), .DW(DB)) u_div_recip (
      .clock(clock), .reset(reset), .start_i(div_start),
      .dividend_i({1'b1, {K{1'b0}}}), .divisor_i(d_ff),
      .busy_o(busy_v[4]), .quotient_o(quo_r), .remainder_o()
   );

   // ---------------- position counters ----------------
   logic [XW-1:0] x_ff, bx_ff;
   logic [HB-1:0] y_ff, by_ff;
   logic [SW-1:0] px_ff, py_ff;
   logic [XW:0]   ow_ff;
   logic [HB-1:0] oh_ff;
   logic [K:0]    recip_ff;

   logic [XW-1:0] x_in, bx_in, cx, cbx;
   logic [HB-1:0] y_in, by_in, cy, cby;
   logic [SW-1:0] px_in, py_in, cpx, cpy, px_inc, py_inc;
   logic [XW:0]   x_inc;
   logic [HB:0]   y_inc;
   logic          adv;
   logic          accept;
   logic          in_range, first0, last0, emit0, we0, rlast0, flast0;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_RUN) && adv;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cx     = req_frame_start ? '0 : x_ff;
      cy     = req_frame_start ? '0 : y_ff;
      cbx    = req_frame_start ? '0 : bx_ff;
      cby    = req_frame_start ? '0 : by_ff;
      cpx    = req_frame_start ? '0 : px_ff;
      cpy    = req_frame_start ? '0 : py_ff;
      px_inc = cpx + SW'(1);
      py_inc = cpy + SW'(1);

      // Inside whole blocks exactly when the block index is below the output size.
      in_range = ({1'b0, cbx} < ow_ff) && (cby < oh_ff);
      first0   = (cpx == '0) && (cpy == '0);
      last0    = (px_inc == sx_ff) && (py_inc == sy_ff);
      emit0    = in_range && (smooth_ff ? last0 : first0);
      we0      = in_range && smooth_ff;
      rlast0   = {1'b0, cbx} == (ow_ff - (XW+1)'(1));
      flast0   = rlast0 && (cby == (oh_ff - HB'(1)));

      x_inc = {1'b0, cx} + (XW+1)'(1);
      y_inc = {1'b0, cy} + (HB+1)'(1);
      x_in  = x_inc[XW-1:0];
      bx_in = cbx;
      px_in = px_inc;
      y_in  = cy;
      by_in = cby;
      py_in = cpy;
      if (px_inc == sx_ff) begin
         px_in = '0;
         bx_in = cbx + XW'(1);
      end
      if (x_inc >= w_ff) begin
         x_in  = '0;
         bx_in = '0;
         px_in = '0;
         if (y_inc >= {1'b0, h_ff}) begin
            y_in  = '0;
            by_in = '0;
            py_in = '0;
         end else begin
            y_in = y_inc[HB-1:0];
            if (py_inc == sy_ff) begin
               py_in = '0;
               by_in = cby + HB'(1);
            end else begin
               py_in = py_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff  <= '0;
         y_ff  <= '0;
         bx_ff <= '0;
         by_ff <= '0;
         px_ff <= '0;
         py_ff <= '0;
      end else if (load) begin
         bx_ff <= quo_x;
         px_ff <= rem_x;
         by_ff <= quo_y;
         py_ff <= rem_y;
      end else if (accept) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         bx_ff <= bx_in;
         by_ff <= by_in;
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ow_ff    <= quo_w;
         oh_ff    <= quo_h;
         recip_ff <= quo_r;
      end
   end

   // ---------------- accumulator RAM and sum update ----------------
   logic [CH-1:0][K-1:0]           block_sums_ff [MAX_WIDTH];
   logic [CH-1:0][K-1:0]           block_rd_ff;
   logic [CH-1:0][K-1:0]           fwd_data_ff;
   logic                           fwd_ff;
   logic                           s1_we_ff, s1_emit_ff;
   logic                           s1_first_ff, s1_rlast_ff, s1_flast_ff;
   logic [XW-1:0]                  s1_addr_ff;
   logic [CH-1:0][SAMPLE_BITS-1:0] s1_pix_ff;
   logic [CH-1:0][K-1:0]           s1_old;
   logic [CH-1:0][K-1:0]           s1_sum;
   logic                           fwd_in;

   always_comb begin
      s1_old = fwd_ff ? fwd_data_ff : block_rd_ff;
      for (int c = 0; c < CH; c++) begin
         s1_sum[c] = s1_first_ff ? K'(s1_pix_ff[c]) : s1_old[c] + K'(s1_pix_ff[c]);
      end
      // The word being written this cycle is the one the next pixel reads.
      fwd_in = s1_we_ff && (s1_addr_ff == cbx);
   end

   always_ff @(posedge clock) begin
      if (adv && s1_we_ff) begin
         block_sums_ff[s1_addr_ff] <= s1_sum;
      end
      if (adv) begin
         block_rd_ff <= block_sums_ff[cbx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_we_ff   <= 1'b0;
         s1_emit_ff <= 1'b0;
      end else if (adv) begin
         s1_we_ff   <= accept && we0;
         s1_emit_ff <= accept && emit0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fwd_ff      <= fwd_in;
         fwd_data_ff <= s1_sum;
         s1_first_ff <= first0;
         s1_rlast_ff <= rlast0;
         s1_flast_ff <= flast0;
         s1_addr_ff  <= cbx;
         s1_pix_ff   <= {req_blue_in, req_green_in, req_red_in};
      end
   end

   // ---------------- division by the block area ----------------
   logic                 s2_emit_ff, s3_emit_ff;
   logic                 s2_rlast_ff, s2_flast_ff, s3_rlast_ff, s3_flast_ff;
   logic [CH-1:0][K-1:0] s2_sum_ff, s3_sum_ff, s3_q_ff;
   logic [CH-1:0][PW-1:0] s2_prod_ff;
   logic [CH-1:0][QW-1:0] s3_qd_ff;
   logic [CH-1:0][K-1:0] s2_q;
   logic [CH-1:0][K-1:0] rem;
   logic [CH-1:0][K-1:0] avg;
   logic [CH-1:0][SAMPLE_BITS-1:0] res;

   always_comb begin
      for (int c = 0; c < CH; c++) begin
         s2_q[c] = s2_prod_ff[c][PW-1:K];
         // The estimate is low by at most one; one remainder check fixes it.
         rem[c]  = s3_sum_ff[c] - s3_qd_ff[c][K-1:0];
         avg[c]  = s3_q_ff[c] + K'(rem[c] >= K'(d_ff));
         res[c]  = smooth_ff ? avg[c][SAMPLE_BITS-1:0] : s3_sum_ff[c][SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
         s3_emit_ff <= 1'b0;
      end else if (adv) begin
         s2_emit_ff <= s1_emit_ff;
         s3_emit_ff <= s2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < CH; c++) begin
            s2_prod_ff[c] <= PW'(s1_sum[c]) * PW'(recip_ff);
            s3_qd_ff[c]   <= QW'(s2_q[c]) * QW'(d_ff);
         end
         s2_sum_ff   <= s1_sum;
         s2_rlast_ff <= s1_rlast_ff;
         s2_flast_ff <= s1_flast_ff;
         s3_sum_ff   <= s2_sum_ff;
         s3_q_ff     <= s2_q;
         s3_rlast_ff <= s2_rlast_ff;
         s3_flast_ff <= s2_flast_ff;
      end
   end

   // ---------------- output register ----------------
   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] red_ff, green_ff, blue_ff;
   logic                   row_last_ff, frame_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s3_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         red_ff        <= res[0];
         green_ff      <= res[1];
         blue_ff       <= res[2];
         row_last_ff   <= s3_rlast_ff;
         frame_last_ff <= s3_flast_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = red_ff;
   assign rsp_green_out  = green_ff;
   assign rsp_blue_out   = blue_ff;
   assign rsp_row_last   = row_last_ff;
   assign rsp_frame_last = frame_last_ff;

endmodule

`default_nettype wire

[sv/idba_checker.sv]
// Port-level checks for the integer box-average downscaler, bound to its top level.
// Depends on idba_pkg for default sizes and register port widths.
`default_nettype none

module idba_checker #(
   parameter int SAMPLE_BITS = idba_pkg::DEF_SAMPLE_BITS
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [SAMPLE_BITS-1:0]             rsp_red_out,
   input wire logic [SAMPLE_BITS-1:0]             rsp_green_out,
   input wire logic [SAMPLE_BITS-1:0]             rsp_blue_out,
   input wire logic                               rsp_row_last,
   input wire logic                               rsp_frame_last,
   input wire logic                               csr_we,
   input wire idba_pkg::csr_index_type            csr_index,
   input wire logic [idba_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   logic unused_ok;
   assign unused_ok = req_valid ^ (|csr_index) ^ (|csr_wdata);

   // Reset leaves no word pending and starts the setup pass.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_ready))
      else $error("output word or input ready right after reset");

   // A register write restarts the setup pass, so no pixel is taken next cycle.
   a_csr_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("input ready in the cycle after a register write");

   // The last word of a picture also closes its output row.
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |-> rsp_row_last)
      else $error("frame_last without row_last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out)
         && $stable(rsp_row_last) && $stable(rsp_frame_last)))
      else $error("stalled output word changed");

endmodule

bind integer_downscale_box_average idba_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_idba_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out), .rsp_blue_out(rsp_blue_out),
   .rsp_row_last(rsp_row_last), .rsp_frame_last(rsp_frame_last),
   .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
);

`default_nettype wire

[tb/sv/integer_downscale_box_average_tb.sv]
// Self-checking testbench for the integer box-average downscaler.
// Depends on idba_pkg and the integer_downscale_box_average RTL; it predicts each
// reduced pixel in-line and compares every output word against that prediction.
`timescale 1ns / 100ps

module integer_downscale_box_average_tb;
   import idba_pkg::*;

   localparam int SB          = DEF_SAMPLE_BITS;
   localparam int MAX_W       = DEF_MAX_WIDTH;
   localparam int MAX_H       = 65535;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 12;
   localparam int RANDOM_PIXELS = 1700;

   typedef struct packed {
      logic [SB-1:0] red;
      logic [SB-1:0] green;
      logic [SB-1:0] blue;
      logic          row_last;
      logic          frame_last;
   } reduced_pixel_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [SB-1:0]            req_red_in = '0;
   logic [SB-1:0]            req_green_in = '0;
   logic [SB-1:0]            req_blue_in = '0;
   logic                     req_frame_start = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b1;
   logic [SB-1:0]            rsp_red_out;
   logic [SB-1:0]            rsp_green_out;
   logic [SB-1:0]            rsp_blue_out;
   logic                     rsp_row_last;
   logic                     rsp_frame_last;
   logic                     csr_we = 1'b0;
   csr_index_type            csr_index = REG_SCALE_Y;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Shadow copy of the registers and of the raster position.
   logic [SCALE_REG_BITS-1:0] scale_y_cfg = RST_SCALE;
   logic [SCALE_REG_BITS-1:0] scale_x_cfg = RST_SCALE;
   logic                      smooth_cfg = 1'b0;
   logic [WIDTH_REG_BITS-1:0] width_cfg = RST_WIDTH;
   logic [HEIGHT_BITS-1:0]    height_cfg = RST_HEIGHT;
   logic [10:0]               col_pos = '0;
   logic [HEIGHT_BITS-1:0]    row_pos = '0;
   logic [15:0]               box_sums [MAX_W][CHANNELS];

   reduced_pixel_t awaited_pixels[$];
   int error_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int stall_left = 0;

   integer_downscale_box_average u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_row_last    (rsp_row_last),
      .rsp_frame_last  (rsp_frame_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t ns: timeout with %0d words outstanding", $time, awaited_pixels.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver back-pressure in bursts of random length.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!reset && $urandom_range(0, 99) < receiver_stall_pct) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      reduced_pixel_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_pixels.size() == 0) begin
            $display("%0t ns: unexpected word, expected none, got rgb %0d %0d %0d", $time,
                     rsp_red_out, rsp_green_out, rsp_blue_out);
            error_count++;
         end else begin
            want = awaited_pixels.pop_front();
            check_field("red_out", want.red, rsp_red_out);
            check_field("green_out", want.green, rsp_green_out);
            check_field("blue_out", want.blue, rsp_blue_out);
            check_field("row_last", want.row_last, rsp_row_last);
            check_field("frame_last", want.frame_last, rsp_frame_last);
         end
      end
   end

   function automatic int effective_scale(input logic [SCALE_REG_BITS-1:0] s);
      if (s == 0) return ZERO_SCALE;
      if (s > DEF_MAX_SCALE) return DEF_MAX_SCALE;
      return s;
   endfunction

   function automatic int effective_dim(input int d, input int limit);
      if (d == 0) return 1;
      if (d > limit) return limit;
      return d;
   endfunction

   // Advances the raster position by one pixel and queues the reduced pixel, if any.
   task automatic predict_downscale(input logic [SB-1:0] red, input logic [SB-1:0] green,
                                    input logic [SB-1:0] blue, input logic frame_start);
      int sx, sy, w, h, ow, oh, x, y, bx, by, px, py, area, nx, ny;
      logic [SB-1:0] pix [CHANNELS];
      reduced_pixel_t res;
      bit emit;
      pix[0] = red;
      pix[1] = green;
      pix[2] = blue;
      sx = effective_scale(scale_x_cfg);
      sy = effective_scale(scale_y_cfg);
      w = effective_dim(width_cfg, MAX_W);
      h = effective_dim(height_cfg, MAX_H);
      ow = w / sx;
      oh = h / sy;
      if (frame_start) begin
         col_pos = '0;
         row_pos = '0;
      end
      x = col_pos;
      y = row_pos;
      emit = 1'b0;
      res = '0;
      if (x < ow * sx && y < oh * sy) begin
         bx = x / sx;
         by = y / sy;
         px = x % sx;
         py = y % sy;
         if (smooth_cfg) begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (px == 0 && py == 0) box_sums[bx][c] = pix[c];
               else box_sums[bx][c] = box_sums[bx][c] + pix[c];
            end
            if (px == sx - 1 && py == sy - 1) begin
               emit = 1'b1;
               area = sx * sy;
               res.red = box_sums[bx][0] / area;
               res.green = box_sums[bx][1] / area;
               res.blue = box_sums[bx][2] / area;
            end
         end else if (px == 0 && py == 0) begin
            emit = 1'b1;
            res.red = red;
            res.green = green;
            res.blue = blue;
         end
         if (emit) begin
            res.row_last = (bx == ow - 1);
            res.frame_last = res.row_last && (by == oh - 1);
            awaited_pixels.push_back(res);
         end
      end
      // Count in int so that a width of 2048 does not wrap the 11-bit column early.
      nx = x + 1;
      if (nx >= w) begin
         col_pos = '0;
         ny = y + 1;
         if (ny >= h) ny = 0;
         row_pos = ny;
      end else begin
         col_pos = nx;
      end
   endtask

   // Leaves valid high on return so that a following word can go back to back.
   task automatic send_pixel(input logic [SB-1:0] red, input logic [SB-1:0] green,
                             input logic [SB-1:0] blue, input logic frame_start);
      req_valid <= 1'b1;
      req_red_in <= red;
      req_green_in <= green;
      req_blue_in <= blue;
      req_frame_start <= frame_start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_downscale(red, green, blue, frame_start);
   endtask

   task automatic maybe_pause();
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_pixels.size() != 0);
   endtask

   // Extra cycles cover pixels still in the pipeline that produce no word.
   task automatic settle_block();
      drain_results();
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_SCALE_Y:      scale_y_cfg = value[SCALE_REG_BITS-1:0];
         REG_SCALE_X:      scale_x_cfg = value[SCALE_REG_BITS-1:0];
         REG_SMOOTH_MODE:  smooth_cfg = value[0];
         REG_IMAGE_WIDTH:  width_cfg = value[WIDTH_REG_BITS-1:0];
         REG_IMAGE_HEIGHT: height_cfg = value[HEIGHT_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input logic [SCALE_REG_BITS-1:0] sy,
                                input logic [SCALE_REG_BITS-1:0] sx, input logic sm,
                                input logic [WIDTH_REG_BITS-1:0] wd,
                                input logic [HEIGHT_BITS-1:0] ht, input logic [4:0] mask);
      settle_block();
      if (mask[REG_SCALE_Y]) write_csr(REG_SCALE_Y, sy);
      if (mask[REG_SCALE_X]) write_csr(REG_SCALE_X, sx);
      if (mask[REG_SMOOTH_MODE]) write_csr(REG_SMOOTH_MODE, sm);
      if (mask[REG_IMAGE_WIDTH]) write_csr(REG_IMAGE_WIDTH, wd);
      if (mask[REG_IMAGE_HEIGHT]) write_csr(REG_IMAGE_HEIGHT, ht);
      csr_we <= 1'b0;
   endtask

   function automatic logic [SB-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic logic [SCALE_REG_BITS-1:0] random_scale();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom_range(17, 31);
         2: return DEF_MAX_SCALE;
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 8;
         default: return 30;
      endcase
   endfunction

   // Reset values: pick mode, 2 by 2 blocks, 640 pixels per row.
   task automatic test_reset_defaults();
      send_pixel(8'd255, 8'd0, 8'd170, 1'b1);
      maybe_pause();
      send_pixel(8'd1, 8'd2, 8'd3, 1'b0);
      maybe_pause();
      send_pixel(8'd0, 8'd255, 8'd85, 1'b0);
      maybe_pause();
   endtask

   // Zero scales act as 2; the odd third column is a partial block and is dropped.
   // The mean of the red samples is not whole, so the truncation shows.
   task automatic test_smooth_zero_scale();
      set_registers(5'd0, 5'd0, 1'b1, 12'd3, 16'd2, 5'b11111);
      send_pixel(8'd255, 8'd255, 8'd0, 1'b1);
      maybe_pause();
      send_pixel(8'd254, 8'd0, 8'd1, 1'b0);
      maybe_pause();
      send_pixel(8'd7, 8'd7, 8'd7, 1'b0);
      maybe_pause();
      send_pixel(8'd255, 8'd255, 8'd1, 1'b0);
      maybe_pause();
      send_pixel(8'd254, 8'd0, 8'd1, 1'b0);
      maybe_pause();
      send_pixel(8'd9, 8'd9, 8'd9, 1'b0);
      maybe_pause();
   endtask

   // Oversized scales clamp to the maximum and a zero-sized picture acts as one pixel,
   // so the picture is smaller than one block and nothing comes out.
   task automatic test_oversize_picture();
      set_registers(5'd20, 5'd31, 1'b1, 12'd0, 16'd0, 5'b11011);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      maybe_pause();
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      maybe_pause();
   endtask

   // Shrinking the width mid-row leaves the column past the end; it must wrap.
   task automatic test_counter_beyond_width();
      set_registers(5'd1, 5'd1, 1'b0, 12'd8, 16'd2, 5'b11111);
      send_pixel(8'd10, 8'd20, 8'd30, 1'b1);
      for (int i = 1; i < 5; i++) begin
         maybe_pause();
         send_pixel(random_sample(), random_sample(), random_sample(), 1'b0);
      end
      set_registers(5'd1, 5'd1, 1'b0, 12'd3, 16'd2, 5'b01000);
      for (int i = 0; i < 3; i++) begin
         send_pixel(random_sample(), random_sample(), random_sample(), 1'b0);
         maybe_pause();
      end
   endtask

   // Random settings per phase; mostly whole pictures with frame_start on the first
   // pixel, with the odd stray frame_start and pictures that wrap on their own.
   task automatic test_random_pictures();
      logic [WIDTH_REG_BITS-1:0] wd;
      logic [HEIGHT_BITS-1:0] ht;
      logic fs;
      int sent, per_pic, count, cap;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         case ($urandom_range(0, 15))
            0: wd = 0;
            1: wd = $urandom_range(25, 200);
            default: wd = $urandom_range(1, 24);
         endcase
         case ($urandom_range(0, 15))
            0: ht = 0;
            1: ht = $urandom_range(0, 65535);
            2: ht = 16'hFFFF;
            default: ht = $urandom_range(1, 20);
         endcase
         set_registers(random_scale(), random_scale(), $urandom_range(0, 1), wd, ht,
                       $urandom_range(1, 31));
         sender_idle_pct = pick_idle_pct();
         receiver_stall_pct = pick_idle_pct();
         per_pic = effective_dim(width_cfg, MAX_W) * effective_dim(height_cfg, MAX_H);
         count = per_pic * $urandom_range(1, 3);
         cap = $urandom_range(30, 400);
         if (count > cap) count = cap;
         for (int i = 0; i < count; i++) begin
            fs = 1'b0;
            // A smooth phase must begin at a block corner so no sum is read unwritten.
            if (i % per_pic == 0) fs = (i == 0 && smooth_cfg) ? 1'b1 : ($urandom_range(0, 7) != 0);
            else if ($urandom_range(0, 99) == 0) fs = 1'b1;
            send_pixel(random_sample(), random_sample(), random_sample(), fs);
            sent++;
            if ($urandom_range(0, 149) == 0) drain_results();
            else maybe_pause();
         end
      end
   endtask

   // Widest row (width register above the maximum clamps to it), one-pixel-wide
   // blocks two rows tall, so every column of the sum memory is written and read.
   task automatic test_widest_rows();
      set_registers(5'd2, 5'd1, 1'b1, 12'hFFF, 16'hFFFF, 5'b11111);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      for (int i = 0; i < 2 * MAX_W; i++)
         send_pixel(random_sample(), random_sample(), random_sample(), i == 0);
   endtask

   initial begin
      sender_idle_pct = 25;
      receiver_stall_pct = 25;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_smooth_zero_scale();
      test_oversize_picture();
      test_counter_beyond_width();
      test_random_pictures();
      test_widest_rows();
      settle_block();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
